/* rtl/flff_pkg.sv */
package flff_pkg;

    localparam int DefaultEntries = 16;

    // Operation codes carried in the input word.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    // Status codes carried in the result word.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

endpackage

/* rtl/free_list_first_fit_unit.sv */
// An insert into a full list, any op on an empty list and the unused op end without reading
// the list; an insert, a remove or a find that misses reads every entry, and a find that hits
// stops at the first entry whose size is at least the requested size.
// Throughput: one word at a time; s_axis_tready stays low until the result word is taken.
// Reset: aresetn (synchronous, active low) empties the list; memory is not cleared.
module free_list_first_fit_unit #(
    parameter int ENTRIES = flff_pkg::DefaultEntries
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], block_address[33:2], insert_size[65:34], request_size[97:66], zero fill
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], found_address[33:2], found_size[65:34], zero fill
    output logic [71:0]  m_axis_tdata
);
    import flff_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [63:0] mem [ENTRIES];
    logic [63:0] rd_reg;
    logic [IW-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    logic [IW-1:0] wr_addr;
    logic [63:0] wr_data;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [63:0] hold_reg, hold_next;
    logic [1:0] op_reg, op_next;
    logic [31:0] key_reg, key_next;
    logic [65:0] res_reg, res_next;
    logic res_vld_reg, res_vld_next;

    // Entry memory: one access per cycle, registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !res_vld_reg;
    assign m_axis_tvalid = res_vld_reg;
    assign m_axis_tdata  = {6'd0, res_reg};

    // Sequencer. Insert shifts head-first, carrying the displaced entry in hold_reg.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        hold_next    = hold_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg;
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = hold_reg;
        if (res_vld_reg && m_axis_tready) begin
            res_vld_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    op_next  = s_axis_tdata[1:0];
                    key_next = (s_axis_tdata[1:0] == OP_FIND) ? s_axis_tdata[97:66]
                                                              : s_axis_tdata[33:2];
                    hold_next = {s_axis_tdata[65:34], s_axis_tdata[33:2]};
                    idx_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (op_reg == OP_INSERT) begin
                    if (count_reg == CW'(ENTRIES)) begin
                        res_next = {32'd0, 32'd0, ST_FULL};
                        state_next = S_DONE;
                    end else if (idx_reg == count_reg) begin
                        // Last write: the carried entry goes to the new tail slot.
                        wr_en = 1'b1;
                        count_next = count_reg + 1'b1;
                        res_next = {32'd0, 32'd0, ST_OK};
                        state_next = S_DONE;
                    end else begin
                        rd_en = 1'b1;
                        state_next = S_CHECK;
                    end
                end else if ((op_reg == OP_REMOVE || op_reg == OP_FIND)
                             && idx_reg < count_reg) begin
                    rd_en = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    res_next = {32'd0, 32'd0, ST_NONE};
                    state_next = S_DONE;
                end
            end
            S_CHECK: begin
                if (op_reg == OP_INSERT) begin
                    // Write the carried entry here and carry the old one onward.
                    wr_en = 1'b1;
                    hold_next = rd_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_READ;
                end else if (op_reg == OP_FIND) begin
                    if (rd_reg[63:32] >= key_reg) begin
                        res_next = {rd_reg, ST_OK};
                        state_next = S_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end else begin
                    if (rd_reg[31:0] == key_reg) begin
                        res_next = {rd_reg, ST_OK};
                        state_next = S_SHIFT;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_SHIFT: begin
                // hold_reg flag: read next entry, then write it one slot lower.
                if (idx_reg + 1'b1 >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end else if (hold_reg[0] == 1'b0 || op_reg != OP_REMOVE) begin
                    rd_en = 1'b1;
                    rd_addr = IW'(idx_reg + 1'b1);
                    hold_next[0] = 1'b1;
                    op_next = OP_REMOVE;
                end else begin
                    wr_en = 1'b1;
                    wr_data = rd_reg;
                    hold_next[0] = 1'b0;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE: begin
                res_vld_next = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            res_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            res_vld_reg <= res_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg  <= (state_reg == S_CHECK && res_next[1:0] == ST_OK
                     && op_reg == OP_REMOVE && state_next == S_SHIFT) ? idx_reg : idx_next;
        hold_reg <= (state_next == S_SHIFT && state_reg == S_CHECK) ? 64'd0 : hold_next;
        op_reg   <= op_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    // The list never grows past its capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ENTRIES))
        else $error("entry count above capacity");

    // A result held for the output is not replaced while waiting.
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No new word is taken while a result is pending.
    a_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with result pending");

    // The count moves only at the end of an operation.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_next != count_reg) |-> state_next == S_DONE)
        else $error("count changed mid-operation");

endmodule
